FILE: rtl/rhpm_pkg.sv
// ----------------------------------------------------------------------------
// rhpm_pkg
// Shared widths, codes and interface types of the rolling hash matcher.
// ----------------------------------------------------------------------------
package rhpm_pkg;

    localparam int HASH_W    = 31;
    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 32;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;

    localparam int MAX_PATTERN_DEF = 64;

    localparam logic [HASH_W-1:0] MODULUS_RESET = HASH_W'(1000007);
    localparam logic [HASH_W-1:0] BASE_RESET    = HASH_W'(2);
    localparam logic [HASH_W-1:0] MODULUS_MIN   = HASH_W'(2);

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_PATTERN = 2'd1,
        CMD_TEXT    = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODULUS = 2'd0,
        REG_BASE    = 2'd1
    } reg_idx_t;

    // request to the serial multiply-add unit: (a*b + c) mod m
    typedef struct packed {
        logic              start;
        logic [HASH_W-1:0] a;
        logic [HASH_W-1:0] b;
        logic [BYTE_W-1:0] c;
    } mm_req_t;

    typedef struct packed {
        logic              done;
        logic [HASH_W-1:0] result;
    } mm_rsp_t;

endpackage

FILE: rtl/rhpm_ram.sv
// ----------------------------------------------------------------------------
// rhpm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rhpm_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/rhpm_modmul.sv
// ----------------------------------------------------------------------------
// rhpm_modmul
// Bit-serial modular multiply-add: result = (a*b + c) mod m, one bit a cycle.
// ----------------------------------------------------------------------------
module rhpm_modmul (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rhpm_pkg::mm_req_t         req,
    input  logic [rhpm_pkg::HASH_W-1:0] m,
    output rhpm_pkg::mm_rsp_t         rsp
);
    import rhpm_pkg::*;

    localparam int CNT_W = $clog2(HASH_W);

    typedef enum logic [4:0] {
        MM_IDLE  = 5'b00001,
        MM_RED_A = 5'b00010,
        MM_MUL   = 5'b00100,
        MM_RED_C = 5'b01000,
        MM_ADD   = 5'b10000
    } mm_state_t;

    mm_state_t         state_reg,  state_next;
    logic [HASH_W-1:0] acc_reg,    acc_next;
    logic [HASH_W-1:0] addend_reg, addend_next;
    logic [HASH_W-1:0] shift_reg,  shift_next;
    logic [HASH_W-1:0] b_reg,      b_next;
    logic [HASH_W-1:0] prod_reg,   prod_next;
    logic [BYTE_W-1:0] c_reg,      c_next;
    logic [CNT_W-1:0]  cnt_reg,    cnt_next;
    logic              done_reg,   done_next;
    logic [HASH_W-1:0] result_reg, result_next;

    logic [HASH_W+1:0] m_ext;
    logic [HASH_W+1:0] t0;
    logic [HASH_W+1:0] t1;
    logic [HASH_W+1:0] t2;
    logic [HASH_W-1:0] step_res;
    logic [HASH_W:0]   sum;
    logic [HASH_W:0]   sum_red;

    // acc <- (2*acc + bit*addend) mod m; acc and addend stay below m
    always_comb
    begin
        m_ext    = {2'b00, m};
        t0       = {1'b0, acc_reg, 1'b0} +
                   (shift_reg[HASH_W-1] ? {2'b00, addend_reg} : '0);
        t1       = (t0 >= m_ext) ? (t0 - m_ext) : t0;
        t2       = (t1 >= m_ext) ? (t1 - m_ext) : t1;
        step_res = t2[HASH_W-1:0];
        sum      = {1'b0, prod_reg} + {1'b0, acc_reg};
        sum_red  = (sum >= {1'b0, m}) ? (sum - {1'b0, m}) : sum;
    end

    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        addend_next = addend_reg;
        shift_next  = shift_reg;
        b_next      = b_reg;
        prod_next   = prod_reg;
        c_next      = c_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        case (state_reg)
            MM_IDLE:
            begin
                if (req.start)
                begin
                    // reduce a first: multiply its bits by one
                    acc_next    = '0;
                    addend_next = HASH_W'(1);
                    shift_next  = req.a;
                    b_next      = req.b;
                    c_next      = req.c;
                    cnt_next    = CNT_W'(HASH_W - 1);
                    state_next  = MM_RED_A;
                end
            end
            MM_RED_A:
            begin
                acc_next   = step_res;
                shift_next = shift_reg << 1;
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    addend_next = step_res;
                    acc_next    = '0;
                    shift_next  = b_reg;
                    cnt_next    = CNT_W'(HASH_W - 1);
                    state_next  = MM_MUL;
                end
            end
            MM_MUL:
            begin
                acc_next   = step_res;
                shift_next = shift_reg << 1;
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    prod_next   = step_res;
                    acc_next    = '0;
                    addend_next = HASH_W'(1);
                    shift_next  = {c_reg, {(HASH_W - BYTE_W){1'b0}}};
                    cnt_next    = CNT_W'(BYTE_W - 1);
                    state_next  = MM_RED_C;
                end
            end
            MM_RED_C:
            begin
                acc_next   = step_res;
                shift_next = shift_reg << 1;
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = MM_ADD;
                end
            end
            MM_ADD:
            begin
                result_next = sum_red[HASH_W-1:0];
                done_next   = 1'b1;
                state_next  = MM_IDLE;
            end
            default:
            begin
                state_next = MM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MM_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        addend_reg <= addend_next;
        shift_reg  <= shift_next;
        b_reg      <= b_next;
        prod_reg   <= prod_next;
        c_reg      <= c_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

FILE: rtl/rolling_hash_pattern_match_top.sv
// ----------------------------------------------------------------------------
// rolling_hash_pattern_match_top
// Streaming rolling hash matcher: pattern hash, windowed text hash, one
// result per text byte.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  in       | in_valid / in_stall    | command, data_byte
//  out      | out_valid / out_stall  | window_full, hash_match, match_start,
//           |                        | window_hash
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  Every hash step runs on one bit-serial multiply-add unit (start, reduce a,
//  multiply by b, reduce c, add, done). in_stall after an accepted request:
//  first pattern byte for its hash step, later ones for hash and power steps;
//  text byte for reduce and hash steps, plus the drop of the oldest byte once
//  the window is full; clear and ignored requests: none. A text byte holds
//  while out_stall holds the previous result. Reset and clear touch only registers.
// ----------------------------------------------------------------------------
module rolling_hash_pattern_match_top #(
    parameter int MAX_PATTERN = rhpm_pkg::MAX_PATTERN_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [rhpm_pkg::CMD_W-1:0]   command,
    input  logic [rhpm_pkg::BYTE_W-1:0]  data_byte,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         window_full,
    output logic                         hash_match,
    output logic [rhpm_pkg::COUNT_W-1:0] match_start,
    output logic [rhpm_pkg::HASH_W-1:0]  window_hash,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rhpm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rhpm_pkg::HASH_W-1:0]  cfg_data
);
    import rhpm_pkg::*;

    localparam int PCNT_W = $clog2(MAX_PATTERN + 1);
    localparam int RING_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    localparam logic [PCNT_W-1:0]  PCNT_MAX  = PCNT_W'(MAX_PATTERN);
    localparam logic [RING_W-1:0]  RING_LAST = RING_W'(MAX_PATTERN - 1);
    localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_PAT_HASH = 8'b0000_0010,
        S_PAT_POW  = 8'b0000_0100,
        S_TXT_RED  = 8'b0000_1000,
        S_TXT_RD   = 8'b0001_0000,
        S_TXT_DROP = 8'b0010_0000,
        S_TXT_HASH = 8'b0100_0000,
        S_EMIT     = 8'b1000_0000
    } state_t;

    state_t             state_reg,   state_next;
    logic [HASH_W-1:0]  modulus_reg, modulus_next;
    logic [HASH_W-1:0]  base_reg,    base_next;
    logic [HASH_W-1:0]  ph_reg,      ph_next;
    logic [HASH_W-1:0]  th_reg,      th_next;
    logic [HASH_W-1:0]  lp_reg,      lp_next;
    logic [HASH_W-1:0]  work_reg,    work_next;
    logic [PCNT_W-1:0]  pcount_reg,  pcount_next;
    logic [COUNT_W-1:0] tcount_reg,  tcount_next;
    logic [RING_W-1:0]  ring_reg,    ring_next;
    logic [BYTE_W-1:0]  byte_reg,    byte_next;
    mm_req_t            mm_req_reg,  mm_req_next;

    logic               out_valid_reg,   out_valid_next;
    logic               window_full_reg, window_full_next;
    logic               hash_match_reg,  hash_match_next;
    logic [COUNT_W-1:0] match_start_reg, match_start_next;
    logic [HASH_W-1:0]  window_hash_reg, window_hash_next;

    mm_rsp_t            mm_rsp;
    logic [HASH_W-1:0]  m_eff;
    logic [COUNT_W-1:0] len_ext;
    logic               window_ready;
    logic [COUNT_W-1:0] tcount_inc;
    logic [PCNT_W-1:0]  ring_ext;
    logic [PCNT_W-1:0]  old_ext;
    logic [RING_W-1:0]  old_pos;
    logic [RING_W-1:0]  ring_inc;
    logic [HASH_W-1:0]  sub_res;
    logic               ram_we;
    logic               ram_re;
    logic [BYTE_W-1:0]  ram_rdata;
    logic               out_free;
    logic               full_now;

    rhpm_modmul u_modmul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mm_req_reg),
        .m     (m_eff),
        .rsp   (mm_rsp)
    );

    rhpm_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PATTERN)
    ) u_window_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ring_reg),
        .wdata (byte_reg),
        .re    (ram_re),
        .raddr (old_pos),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        m_eff        = (modulus_reg < MODULUS_MIN) ? MODULUS_MIN : modulus_reg;
        len_ext      = COUNT_W'(pcount_reg);
        window_ready = (tcount_reg >= len_ext);
        tcount_inc   = (tcount_reg == COUNT_SAT) ? tcount_reg : (tcount_reg + 1'b1);
        ring_ext     = PCNT_W'(ring_reg);
        old_ext      = (ring_ext >= pcount_reg) ? (ring_ext - pcount_reg)
                                                : (ring_ext + (PCNT_MAX - pcount_reg));
        old_pos      = old_ext[RING_W-1:0];
        ring_inc     = (ring_reg == RING_LAST) ? '0 : (ring_reg + 1'b1);
        // (reduced text hash - dropped term) mod m
        sub_res      = (work_reg >= mm_rsp.result) ? (work_reg - mm_rsp.result)
                                                   : (work_reg + (m_eff - mm_rsp.result));
        out_free     = !out_valid_reg || !out_stall;
        full_now     = (pcount_reg != '0) && window_ready;
    end

    assign ram_re = (state_reg == S_TXT_RED) && mm_rsp.done && window_ready;
    assign ram_we = (state_reg == S_TXT_HASH) && mm_rsp.done;

    // configuration registers
    always_comb
    begin
        modulus_next = modulus_reg;
        base_next    = base_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_MODULUS: modulus_next = cfg_data;
                REG_BASE:    base_next    = cfg_data;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        ph_next           = ph_reg;
        th_next           = th_reg;
        lp_next           = lp_reg;
        work_next         = work_reg;
        pcount_next       = pcount_reg;
        tcount_next       = tcount_reg;
        ring_next         = ring_reg;
        byte_next         = byte_reg;
        mm_req_next       = mm_req_reg;
        mm_req_next.start = 1'b0;
        window_full_next  = window_full_reg;
        hash_match_next   = hash_match_reg;
        match_start_next  = match_start_reg;
        window_hash_next  = window_hash_reg;
        out_valid_next    = out_valid_reg && out_stall;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (command)
                        CMD_CLEAR:
                        begin
                            ph_next     = '0;
                            th_next     = '0;
                            lp_next     = HASH_W'(1);
                            pcount_next = '0;
                            tcount_next = '0;
                            ring_next   = '0;
                        end
                        CMD_PATTERN:
                        begin
                            // drop pattern bytes once text started or pattern full
                            if ((tcount_reg == '0) && (pcount_reg < PCNT_MAX))
                            begin
                                mm_req_next = '{start: 1'b1, a: ph_reg, b: base_reg,
                                                c: data_byte};
                                state_next  = S_PAT_HASH;
                            end
                        end
                        CMD_TEXT:
                        begin
                            if (pcount_reg == '0)
                            begin
                                tcount_next = tcount_inc;
                                state_next  = S_EMIT;
                            end
                            else
                            begin
                                byte_next   = data_byte;
                                mm_req_next = '{start: 1'b1, a: th_reg, b: HASH_W'(1),
                                                c: '0};
                                state_next  = S_TXT_RED;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_PAT_HASH:
            begin
                if (mm_rsp.done)
                begin
                    ph_next = mm_rsp.result;
                    if (pcount_reg != '0)
                    begin
                        mm_req_next = '{start: 1'b1, a: lp_reg, b: base_reg, c: '0};
                        state_next  = S_PAT_POW;
                    end
                    else
                    begin
                        lp_next     = HASH_W'(1);
                        pcount_next = pcount_reg + 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end
            S_PAT_POW:
            begin
                if (mm_rsp.done)
                begin
                    lp_next     = mm_rsp.result;
                    pcount_next = pcount_reg + 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_TXT_RED:
            begin
                if (mm_rsp.done)
                begin
                    work_next = mm_rsp.result;
                    if (window_ready)
                    begin
                        state_next = S_TXT_RD;
                    end
                    else
                    begin
                        mm_req_next = '{start: 1'b1, a: mm_rsp.result, b: base_reg,
                                        c: byte_reg};
                        state_next  = S_TXT_HASH;
                    end
                end
            end
            S_TXT_RD:
            begin
                // oldest byte is in the RAM read register now
                mm_req_next = '{start: 1'b1, a: lp_reg, b: HASH_W'(ram_rdata), c: '0};
                state_next  = S_TXT_DROP;
            end
            S_TXT_DROP:
            begin
                if (mm_rsp.done)
                begin
                    mm_req_next = '{start: 1'b1, a: sub_res, b: base_reg, c: byte_reg};
                    state_next  = S_TXT_HASH;
                end
            end
            S_TXT_HASH:
            begin
                if (mm_rsp.done)
                begin
                    th_next     = mm_rsp.result;
                    ring_next   = ring_inc;
                    tcount_next = tcount_inc;
                    state_next  = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    window_full_next = full_now;
                    hash_match_next  = full_now && (th_reg == ph_reg);
                    if (!full_now)
                    begin
                        match_start_next = '0;
                    end
                    else if (tcount_reg == COUNT_SAT)
                    begin
                        match_start_next = COUNT_SAT;
                    end
                    else
                    begin
                        match_start_next = tcount_reg - len_ext;
                    end
                    window_hash_next = (pcount_reg != '0) ? th_reg : '0;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            modulus_reg   <= MODULUS_RESET;
            base_reg      <= BASE_RESET;
            ph_reg        <= '0;
            th_reg        <= '0;
            lp_reg        <= HASH_W'(1);
            pcount_reg    <= '0;
            tcount_reg    <= '0;
            ring_reg      <= '0;
            mm_req_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            modulus_reg   <= modulus_next;
            base_reg      <= base_next;
            ph_reg        <= ph_next;
            th_reg        <= th_next;
            lp_reg        <= lp_next;
            pcount_reg    <= pcount_next;
            tcount_reg    <= tcount_next;
            ring_reg      <= ring_next;
            mm_req_reg    <= mm_req_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg        <= work_next;
        byte_reg        <= byte_next;
        window_full_reg <= window_full_next;
        hash_match_reg  <= hash_match_next;
        match_start_reg <= match_start_next;
        window_hash_reg <= window_hash_next;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign window_full = window_full_reg;
    assign hash_match  = hash_match_reg;
    assign match_start = match_start_reg;
    assign window_hash = window_hash_reg;

endmodule
